@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// ante holds -> cons holds in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// cond holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)

`endif

`endif

@@ sv/mfx_pkg.sv @@
// ----------------------------------------------------------------------------
// mfx_pkg
// Shared types and defaults of the message FIFO with XOR check byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfx_pkg;

  localparam int BYTE_DEPTH_DEF    = 1024;
  localparam int MSG_DEPTH_DEF     = 16;
  localparam int MAX_MSG_BYTES_DEF = 255;

  // message length (check byte included) and in-message position
  localparam int LEN_W = 9;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_in;
  } mfx_in_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data_out;
    logic       last;
    logic [4:0] message_count;
  } mfx_out_t;

endpackage

@@ sv/message_fifo_with_xor_check_core.sv @@
// ----------------------------------------------------------------------------
// message_fifo_with_xor_check_core
// Message FIFO over a byte ring and a descriptor ring, XOR check byte on close.
// ----------------------------------------------------------------------------
// Result: registered from the execute state, once the accepted item commits.
// Items: a new item is accepted only in idle, after the last result is stored;
//   the read of the byte and descriptor memories is issued at accept.
// A stalled output holds the item in execute until the result can be stored.
// Reset (rst, synchronous): pointers, counts and open-message state cleared,
//   mode discard; memory contents are not cleared and read only once written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module message_fifo_with_xor_check_core #(
  parameter int BYTE_DEPTH    = mfx_pkg::BYTE_DEPTH_DEF,
  parameter int MSG_DEPTH     = mfx_pkg::MSG_DEPTH_DEF,
  parameter int MAX_MSG_BYTES = mfx_pkg::MAX_MSG_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // input item channel
  input  logic             in_valid,
  output logic             in_ready,
  input  mfx_pkg::mfx_in_t in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output mfx_pkg::mfx_out_t out_data,
  // mode register write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);

  import mfx_pkg::*;

  // widths derived from the ring depths
  localparam int PTR_W = $clog2(BYTE_DEPTH);
  localparam int CNT_W = $clog2(BYTE_DEPTH + 1);
  localparam int MP_W  = $clog2(MSG_DEPTH);
  localparam int MC_W  = $clog2(MSG_DEPTH + 1);
  localparam int EW    = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 2;
  localparam int MCO_W = $bits(out_data.message_count);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // mode register: 0 discard when full, 1 overwrite oldest
  logic mode;

  // latched input transaction
  mfx_in_t item;

  // byte ring and message ring control
  logic [PTR_W-1:0] wp, wp_next;
  logic [PTR_W-1:0] rp, rp_next;
  logic [CNT_W-1:0] bc, bc_next;
  logic [MP_W-1:0]  head, head_next;
  logic [MP_W-1:0]  tail, tail_next;
  logic [MC_W-1:0]  mcnt, mcnt_next;
  logic             msg_open, msg_open_next;
  logic             msg_rejected, msg_rejected_next;
  logic [7:0]       xr, xr_next;
  logic [LEN_W-1:0] olen, olen_next;
  logic [LEN_W-1:0] rpos, rpos_next;

  // memory ports
  logic             byte_we;
  logic [PTR_W-1:0] byte_waddr;
  logic [7:0]       byte_wdata;
  logic [7:0]       byte_rdata;
  logic             off_we;
  logic [MP_W-1:0]  off_waddr;
  logic [PTR_W-1:0] off_wdata;
  logic [PTR_W-1:0] off_rdata;
  logic             len_we;
  logic [MP_W-1:0]  len_waddr;
  logic [LEN_W-1:0] len_wdata;
  logic [LEN_W-1:0] len_rdata;

  logic accept;
  logic out_free;
  logic commit;

  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] rp_inc;
  logic [MP_W-1:0]  head_inc;
  logic [MP_W-1:0]  tail_inc;
  logic             byte_full;
  logic             msg_full;
  logic             push_ok;
  logic [EW-1:0]    back_sum;
  logic [PTR_W-1:0] wp_back;
  logic [CNT_W-1:0] bc_back;
  logic [CNT_W-1:0] drop_diff;
  mfx_out_t         res;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign commit    = (state == S_EXEC) && out_free;

  assign wp_inc   = (wp == PTR_W'(BYTE_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign rp_inc   = (rp == PTR_W'(BYTE_DEPTH - 1)) ? '0 : rp + 1'b1;
  assign head_inc = (head == MP_W'(MSG_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == MP_W'(MSG_DEPTH - 1)) ? '0 : tail + 1'b1;

  assign byte_full = (bc == CNT_W'(BYTE_DEPTH));
  assign msg_full  = (mcnt == MC_W'(MSG_DEPTH));
  assign push_ok   = !byte_full || mode;

  // ---------------------------------------------------------------------------
  // Memories. Reads are issued at accept from the pointers as they stand:
  // the head byte, the head length, and the offset of the message after the
  // head (needed when a commit into a full ring drops the oldest message).
  // Writes happen only in the execute cycle, so no read meets a write to
  // the same entry in one cycle.
  // ---------------------------------------------------------------------------
  mfx_ram #(
    .DEPTH (BYTE_DEPTH),
    .WIDTH (8)
  ) u_byte_ram (
    .clk   (clk),
    .we    (byte_we && commit),
    .waddr (byte_waddr),
    .wdata (byte_wdata),
    .re    (accept),
    .raddr (rp),
    .rdata (byte_rdata)
  );

  mfx_ram #(
    .DEPTH (MSG_DEPTH),
    .WIDTH (PTR_W)
  ) u_off_ram (
    .clk   (clk),
    .we    (off_we && commit),
    .waddr (off_waddr),
    .wdata (off_wdata),
    .re    (accept),
    .raddr (head_inc),
    .rdata (off_rdata)
  );

  mfx_ram #(
    .DEPTH (MSG_DEPTH),
    .WIDTH (LEN_W)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we && commit),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .re    (accept),
    .raddr (head),
    .rdata (len_rdata)
  );

  // ---------------------------------------------------------------------------
  // Execute: one read-modify-write of the ring state per item.
  // ---------------------------------------------------------------------------
  always_comb begin
    wp_next           = wp;
    rp_next           = rp;
    bc_next           = bc;
    head_next         = head;
    tail_next         = tail;
    mcnt_next         = mcnt;
    msg_open_next     = msg_open;
    msg_rejected_next = msg_rejected;
    xr_next           = xr;
    olen_next         = olen;
    rpos_next         = rpos;

    byte_we    = 1'b0;
    byte_waddr = wp;
    byte_wdata = item.data_in;
    off_we     = 1'b0;
    off_waddr  = tail;
    off_wdata  = wp;
    len_we     = 1'b0;
    len_waddr  = tail;
    len_wdata  = olen;

    res        = '0;
    res.status = ST_OK;

    back_sum  = '0;
    wp_back   = wp;
    bc_back   = bc;
    drop_diff = '0;

    case (item.cmd)
      CMD_PUSH, CMD_CLOSE: begin
        // first byte or a bare close opens a message
        if (!msg_open) begin
          msg_open_next = 1'b1;
          if (msg_full && !mode) begin
            msg_rejected_next = 1'b1;
          end else begin
            msg_rejected_next = 1'b0;
            off_we            = 1'b1;
            olen_next         = '0;
            xr_next           = '0;
          end
        end

        if (item.cmd == CMD_PUSH) begin
          if (msg_rejected_next) begin
            res.status = ST_FULL;
          end else if (olen_next >= LEN_W'(MAX_MSG_BYTES)) begin
            res.status = ST_LONG;
          end else if (!push_ok) begin
            res.status = ST_FULL;
          end else begin
            byte_we = 1'b1;
            wp_next = wp_inc;
            if (byte_full) begin
              rp_next = wp_inc;
            end else begin
              bc_next = bc + 1'b1;
            end
            olen_next = olen_next + 1'b1;
            xr_next   = xr_next ^ item.data_in;
          end
        end else begin
          msg_open_next = 1'b0;
          if (msg_rejected_next) begin
            msg_rejected_next = 1'b0;
            res.status        = ST_FULL;
          end else if (!push_ok) begin
            // check byte does not fit: withdraw the whole open message
            back_sum = EW'(wp) + EW'(BYTE_DEPTH) - EW'(olen_next);
            if (back_sum[EW-1]) begin
              wp_back = back_sum[PTR_W-1:0];
            end else if (back_sum >= EW'(BYTE_DEPTH)) begin
              wp_back = PTR_W'(back_sum - EW'(BYTE_DEPTH));
            end else begin
              wp_back = back_sum[PTR_W-1:0];
            end
            bc_back = (EW'(bc) >= EW'(olen_next)) ?
                      CNT_W'(EW'(bc) - EW'(olen_next)) : '0;
            wp_next    = wp_back;
            bc_next    = bc_back;
            res.status = ST_FULL;
          end else begin
            byte_we    = 1'b1;
            byte_wdata = xr_next;
            wp_next    = wp_inc;
            if (byte_full) begin
              rp_next = wp_inc;
            end else begin
              bc_next = bc + 1'b1;
            end
            len_we    = 1'b1;
            len_wdata = olen_next + 1'b1;
            tail_next = tail_inc;
            if (!msg_full) begin
              mcnt_next = mcnt + 1'b1;
            end else begin
              // ring full: drop the oldest message, reread from new head
              head_next = head_inc;
              rp_next   = off_rdata;
              rpos_next = '0;
              if (wp_inc >= off_rdata) begin
                drop_diff = CNT_W'(wp_inc) - CNT_W'(off_rdata);
              end else begin
                drop_diff = CNT_W'(wp_inc) + CNT_W'(BYTE_DEPTH) - CNT_W'(off_rdata);
              end
              bc_next = (drop_diff == '0) ? CNT_W'(BYTE_DEPTH) : drop_diff;
            end
          end
        end
      end

      CMD_READ: begin
        if (mcnt == '0) begin
          res.status = ST_EMPTY;
        end else begin
          if (bc != '0) begin
            res.data_out = byte_rdata;
            rp_next      = rp_inc;
            bc_next      = bc - 1'b1;
          end
          if (((LEN_W + 1)'(rpos) + 1'b1) >= (LEN_W + 1)'(len_rdata)) begin
            res.last  = 1'b1;
            rpos_next = '0;
            head_next = head_inc;
            mcnt_next = mcnt - 1'b1;
          end else begin
            rpos_next = rpos + 1'b1;
          end
        end
      end

      CMD_CLEAR: begin
        wp_next           = '0;
        rp_next           = '0;
        bc_next           = '0;
        head_next         = '0;
        tail_next         = '0;
        mcnt_next         = '0;
        msg_open_next     = 1'b0;
        msg_rejected_next = 1'b0;
        xr_next           = '0;
        olen_next         = '0;
        rpos_next         = '0;
      end

      default: begin
        res.status = ST_OK;
      end
    endcase

    res.message_count = MCO_W'(mcnt_next);
  end

  // ---------------------------------------------------------------------------
  // State, ring registers and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    if (commit) begin
      out_data <= res;
    end

    if (rst) begin
      state        <= S_IDLE;
      mode         <= 1'b0;
      out_valid    <= 1'b0;
      wp           <= '0;
      rp           <= '0;
      bc           <= '0;
      head         <= '0;
      tail         <= '0;
      mcnt         <= '0;
      msg_open     <= 1'b0;
      msg_rejected <= 1'b0;
      xr           <= '0;
      olen         <= '0;
      rpos         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
      end

      case (state)
        S_IDLE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
          end
          if (accept) begin
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          if (out_free) begin
            state        <= S_IDLE;
            out_valid    <= 1'b1;
            wp           <= wp_next;
            rp           <= rp_next;
            bc           <= bc_next;
            head         <= head_next;
            tail         <= tail_next;
            mcnt         <= mcnt_next;
            msg_open     <= msg_open_next;
            msg_rejected <= msg_rejected_next;
            xr           <= xr_next;
            olen         <= olen_next;
            rpos         <= rpos_next;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_bc_bound, clk, rst, bc <= CNT_W'(BYTE_DEPTH), "byte count over depth")
  `ASSERT_ALWAYS(a_mcnt_bound, clk, rst, mcnt <= MC_W'(MSG_DEPTH), "message count over depth")
  `ASSERT_IMPL(a_rej_open, clk, rst, msg_rejected, msg_open, "rejected message not open")
  `ASSERT_NEXT(a_stall_hold, clk, rst, (state == S_EXEC) && !out_free, (state == S_EXEC) && $stable(mcnt) && $stable(wp), "ring state moved under output stall")
  `ASSERT_NEXT(a_last_pop, clk, rst, commit && (item.cmd == CMD_READ) && res.last, mcnt == $past(mcnt) - 1'b1, "last byte did not retire a message")

endmodule

@@ sv/mfx_ram.sv @@
// ----------------------------------------------------------------------------
// mfx_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfx_ram #(
  parameter int DEPTH = mfx_pkg::MSG_DEPTH_DEF,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the message FIFO with XOR check byte. A queue-fed
// driver and a clocked monitor run against a local model of the byte ring
// and descriptor ring, in discard and overwrite modes, with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mfx_pkg::*;

  localparam int BYTES       = BYTE_DEPTH_DEF;
  localparam int MSGS        = MSG_DEPTH_DEF;
  localparam int MAX_DATA    = MAX_MSG_BYTES_DEF;
  localparam int BP_W        = $clog2(BYTES);
  localparam int MP_W        = $clog2(MSGS);
  localparam int QUIET_LIMIT = 3000;  // idle edges before the run is declared hung
  localparam int LONG_HOLD   = 300;   // receiver back-pressure burst, in cycles

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic     clk;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  mfx_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  mfx_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_data  = 1'b0;

  message_fifo_with_xor_check_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Bench bookkeeping
  // --------------------------------------------------------------------------
  mfx_in_t  item_backlog[$];      // items waiting for the driver
  mfx_out_t awaited_results[$];   // predicted results, oldest first
  int       items_queued  = 0;
  int       items_taken   = 0;
  int       results_seen  = 0;
  int       ends_seen     = 0;
  int       errors        = 0;
  int       status_hits[4] = '{default: 0};
  int       send_idle     = 0;    // percent of edges the driver holds back
  int       recv_idle     = 0;    // percent of edges the receiver stalls
  bit       hold_request  = 1'b0; // asks the receiver for one long stall
  int       hold_left     = 0;
  int       quiet_cycles  = 0;

  // --------------------------------------------------------------------------
  // Local model of the FIFO state
  // --------------------------------------------------------------------------
  logic [7:0]      byte_mem [BYTES];
  logic [BP_W-1:0] wr_ptr     = '0;
  logic [BP_W-1:0] rd_ptr     = '0;
  logic [BP_W:0]   fill_cnt   = '0;
  logic [BP_W-1:0] desc_off [MSGS];
  logic [8:0]      desc_len [MSGS];
  logic [MP_W-1:0] head       = '0;
  logic [MP_W-1:0] tail       = '0;
  logic [MP_W:0]   msg_cnt    = '0;
  logic            in_message = 1'b0;
  logic            refused    = 1'b0;  // open message turned away, ring was full
  logic            overwrite  = 1'b0;  // mode register copy
  logic [7:0]      check_acc  = '0;
  logic [8:0]      open_len   = '0;
  logic [8:0]      rpos       = '0;

  // Append one byte to the ring; in overwrite mode a full ring loses its
  // oldest byte and the read point follows the write point.
  function automatic logic store_byte(logic [7:0] b);
    if (fill_cnt >= BYTES && !overwrite) return 1'b0;
    byte_mem[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;
    if (fill_cnt >= BYTES) rd_ptr = wr_ptr;
    else fill_cnt = fill_cnt + 1'b1;
    return 1'b1;
  endfunction

  function automatic void start_message();
    in_message = 1'b1;
    refused = (msg_cnt >= MSGS) && !overwrite;
    if (!refused) begin
      desc_off[tail] = wr_ptr;
      open_len = '0;
      check_acc = '0;
    end
  endfunction

  function automatic mfx_out_t fifo_result_of(mfx_in_t item);
    mfx_out_t        r;
    logic [BP_W-1:0] span;
    r = '0;
    r.status = ST_OK;
    case (item.cmd)
      CMD_PUSH: begin
        if (!in_message) start_message();
        if (refused) r.status = ST_FULL;
        else if (open_len >= MAX_DATA) r.status = ST_LONG;
        else if (!store_byte(item.data_in)) r.status = ST_FULL;
        else begin
          open_len = open_len + 1'b1;
          check_acc = check_acc ^ item.data_in;
        end
      end
      CMD_CLOSE: begin
        // close with nothing open commits a message holding only check byte 0
        if (!in_message) start_message();
        in_message = 1'b0;
        if (refused) begin
          refused = 1'b0;
          r.status = ST_FULL;
        end else if (!store_byte(check_acc)) begin
          // no room for the check byte: withdraw the whole open message
          wr_ptr = wr_ptr - BP_W'(open_len);
          fill_cnt = (fill_cnt >= open_len) ? fill_cnt - open_len : '0;
          r.status = ST_FULL;
        end else begin
          desc_len[tail] = open_len + 1'b1;
          tail = tail + 1'b1;
          if (msg_cnt < MSGS) msg_cnt = msg_cnt + 1'b1;
          else begin
            // descriptor ring full: oldest message dropped, byte count
            // rebuilt from the pointers (equal pointers mean a full ring)
            head = head + 1'b1;
            rd_ptr = desc_off[head];
            rpos = '0;
            span = wr_ptr - rd_ptr;
            fill_cnt = (span == 0) ? (BP_W + 1)'(BYTES) : {1'b0, span};
          end
        end
      end
      CMD_READ: begin
        if (msg_cnt == 0) r.status = ST_EMPTY;
        else begin
          // bytes may all be overwritten while messages remain: data 0
          if (fill_cnt != 0) begin
            r.data_out = byte_mem[rd_ptr];
            rd_ptr = rd_ptr + 1'b1;
            fill_cnt = fill_cnt - 1'b1;
          end
          if (rpos + 1'b1 >= desc_len[head]) begin
            r.last = 1'b1;
            rpos = '0;
            head = head + 1'b1;
            msg_cnt = msg_cnt - 1'b1;
          end else rpos = rpos + 1'b1;
        end
      end
      CMD_CLEAR: begin
        wr_ptr = '0;
        rd_ptr = '0;
        fill_cnt = '0;
        head = '0;
        tail = '0;
        msg_cnt = '0;
        in_message = 1'b0;
        refused = 1'b0;
        check_acc = '0;
        open_len = '0;
        rpos = '0;
      end
      default: r.status = ST_OK;
    endcase
    r.message_count = msg_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one transaction in flight, valid held until accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (!in_valid || in_ready) begin
      if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_data  <= item_backlog.pop_front();
        in_valid <= 1'b1;
      end else in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on input transactions, checks output transactions
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    mfx_out_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) overwrite = cfg_data;
      if (in_valid && in_ready) begin
        awaited_results.push_back(fifo_result_of(in_data));
        items_taken++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, expected nothing, got %h",
                   $time, out_data);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 8'(want.status), 8'(out_data.status));
          check_field("data_out", want.data_out, out_data.data_out);
          check_field("last", 8'(want.last), 8'(out_data.last));
          check_field("message_count", 8'(want.message_count),
                      8'(out_data.message_count));
          status_hits[want.status]++;
          if (want.last) ends_seen++;
        end
      end
    end
  end

  // Watchdog: a long stretch with no transaction on any channel is a hang
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_item(cmd_t c, logic [7:0] d);
    item_backlog.push_back('{cmd: c, data_in: d});
    items_queued++;
  endtask

  task automatic add_message(int n);
    repeat (n) add_item(CMD_PUSH, 8'($urandom));
    add_item(CMD_CLOSE, 8'($urandom));
  endtask

  task automatic add_reads(int n);
    repeat (n) add_item(CMD_READ, 8'($urandom));
  endtask

  // every item accepted and every result returned
  task automatic wait_all_results();
    while (items_taken != items_queued || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  // mode writes only with the block drained
  task automatic set_mode(logic m);
    wait_all_results();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly whole messages and read bursts; some noise, rare clears. Message
  // sizes are mostly short, a few medium length.
  task automatic add_random_items(int quota);
    int stop_at;
    int pick;
    int n;
    stop_at = items_queued + quota;
    while (items_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        n = $urandom_range(99);
        if (n < 80) n = $urandom_range(12);
        else n = $urandom_range(40, 13);
        add_message(n);
      end else if (pick < 88) add_reads($urandom_range(16, 1));
      else if (pick < 97)
        repeat ($urandom_range(4, 1)) add_item(cmd_t'($urandom_range(3)), 8'($urandom));
      else add_item(CMD_CLEAR, 8'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Discard mode; slow sender, busy receiver
    send_idle = 34;
    recv_idle = 73;
    set_mode(1'b0);
    add_item(CMD_READ, 8'h00);               // nothing stored: empty
    add_item(CMD_PUSH, 8'h00);
    add_item(CMD_PUSH, 8'hFF);
    add_item(CMD_PUSH, 8'h5A);
    add_item(CMD_CLOSE, 8'hFF);
    add_reads(5);                            // check byte flagged, then empty
    add_message(MAX_DATA + 1);               // one byte past the length limit
    add_item(CMD_CLEAR, 8'h00);
    repeat (MSGS) add_item(CMD_CLOSE, 8'h00); // check-only messages up to the limit
    add_item(CMD_CLOSE, 8'h00);              // no room for another descriptor
    add_item(CMD_PUSH, 8'h11);               // message turned away
    add_item(CMD_PUSH, 8'hEE);
    add_item(CMD_CLOSE, 8'h00);
    add_reads(2);
    add_item(CMD_CLEAR, 8'hFF);
    add_item(CMD_READ, 8'hFF);
    add_random_items(30);

    // Overwrite mode; roles of the two sides swapped
    set_mode(1'b1);
    send_idle = 73;
    recv_idle = 34;
    add_item(CMD_CLEAR, 8'h00);
    repeat (MSGS) add_item(CMD_CLOSE, 8'h00);
    add_message(2);                          // commit on a full ring drops oldest
    add_reads(3);
    add_random_items(30);

    // Back to discard; no idling, one long receiver hold-off up front so
    // the block fills and pushes back on the driver
    set_mode(1'b0);
    send_idle = 0;
    recv_idle = 0;
    hold_request = 1'b1;
    add_random_items(40);

    wait_all_results();
    repeat (12) @(posedge clk);
    $display("Covered %0d item transactions, %0d results, %0d message ends, both modes",
             items_taken, results_seen, ends_seen);
    $display("Status mix ok/full/empty/too-long: %0d/%0d/%0d/%0d",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_LONG]);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/mfx_pkg.sv
sv/mfx_ram.sv
sv/message_fifo_with_xor_check_core.sv
tb/tb_top.sv
